@@ sv/crmc_pkg.sv @@
// shared types and constants for the calorimeter region peak and centroid block
`timescale 1ns / 1ps
package crmc_pkg;
	localparam int NREG = 5;
	localparam int MAX_TOWERS = 4096;
	localparam int CNT_W = $clog2(MAX_TOWERS + 1);
	localparam int ESUM_W = 28;
	localparam int WSUM_W = 40;
	localparam int QDEPTH = 2;
	localparam logic [ESUM_W-1:0] ESUM_MAX = {ESUM_W{1'b1}};

	// one classified tower (or end marker) between front and back
	typedef struct packed {
		logic              take;
		logic [15:0]       en_e;
		logic [15:0]       en_h;
		logic [15:0]       en_t;
		logic signed [10:0] eta;
		logic signed [9:0]  phi;
		logic [NREG-1:0]   flag;
		logic [NREG-1:0]   qual;
		logic              last;
	} item_t;

	// one region's accumulated event results
	typedef struct packed {
		logic [15:0]              best_e;
		logic signed [10:0]       best_eta;
		logic signed [9:0]        best_phi;
		logic [ESUM_W-1:0]        esum;
		logic signed [WSUM_W-1:0] weta;
		logic signed [WSUM_W-1:0] wphi;
	} acc_t;
endpackage

@@ sv/crmc_front.sv @@
// front part: tower counting and a small item queue
`timescale 1ns / 1ps
module crmc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	output logic            s_ready,
	input  crmc_pkg::item_t s_item,
	output logic            q_valid,
	input  logic            q_ready,
	output crmc_pkg::item_t q_item
);
	import crmc_pkg::*;
	item_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [CNT_W-1:0] tcount_q;
	logic push, pop;
	item_t it;

	assign s_ready = (cnt_q != 2'(QDEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];
	assign push = s_valid && s_ready;
	assign pop = q_valid && q_ready;

	always_comb begin
		it = s_item;
		it.take = s_item.take && (tcount_q < CNT_W'(MAX_TOWERS));
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
			tcount_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
				if (s_item.last) tcount_q <= '0;
				else if (it.take) tcount_q <= tcount_q + 1'b1;
			end
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ sv/crmc_div.sv @@
// serial restoring divider: signed 40-bit dividend by unsigned 28-bit divisor, toward zero
`timescale 1ns / 1ps
module crmc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [crmc_pkg::WSUM_W-1:0] dividend,
	input  logic [crmc_pkg::ESUM_W-1:0]       divisor,
	output logic                              done,
	output logic signed [crmc_pkg::WSUM_W:0]  quotient
);
	import crmc_pkg::*;
	logic [WSUM_W-1:0] q_q;
	logic [ESUM_W:0] r_q;
	logic [ESUM_W-1:0] d_q;
	logic neg_q, busy_q;
	logic [$clog2(WSUM_W+1)-1:0] n_q;
	logic [ESUM_W:0] rs;
	logic [WSUM_W-1:0] mag;

	assign mag = dividend[WSUM_W-1] ? WSUM_W'(-dividend) : dividend;
	assign rs = {r_q[ESUM_W-1:0], q_q[WSUM_W-1]};
	assign quotient = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= ($clog2(WSUM_W+1))'(WSUM_W);
			end else if (busy_q) begin
				n_q <= n_q - 1'b1;
				if (n_q == 1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= mag;
			r_q <= '0;
			d_q <= divisor;
			neg_q <= dividend[WSUM_W-1];
		end else if (busy_q) begin
			if (rs >= {1'b0, d_q}) begin
				r_q <= rs - {1'b0, d_q};
				q_q <= {q_q[WSUM_W-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[WSUM_W-2:0], 1'b0};
			end
		end
	end
endmodule

@@ sv/crmc_back.sv @@
// back part: per-region accumulation, then the five per-event results
`timescale 1ns / 1ps
module crmc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  crmc_pkg::item_t q_item,
	output logic            m_valid,
	input  logic            m_ready,
	output logic [95:0]     m_data
);
	import crmc_pkg::*;
	typedef enum logic [3:0] {
		ST_ACC = 4'b0001, ST_DETA = 4'b0010, ST_DPHI = 4'b0100, ST_OUT = 4'b1000
	} st_t;
	st_t st_q;
	acc_t acc_q [NREG];
	logic [2:0] reg_q;
	logic signed [10:0] meta_q;
	logic dstart;
	logic ddone;
	logic signed [WSUM_W:0] dq;
	logic signed [WSUM_W-1:0] dnum;
	logic signed [WSUM_W:0] wn_e [NREG];
	logic signed [WSUM_W:0] wn_p [NREG];
	logic [15:0] en [NREG];
	logic [ESUM_W:0] es [NREG];
	logic signed [9:0] mphi;
	acc_t cur;

	assign q_ready = (st_q == ST_ACC);
	assign cur = acc_q[reg_q];
	assign dnum = (st_q == ST_DETA) ? cur.weta : cur.wphi;

	always_comb begin
		en[0] = q_item.en_e; en[1] = q_item.en_e; en[2] = q_item.en_h;
		en[3] = q_item.en_h; en[4] = q_item.en_t;
		for (int r = 0; r < NREG; r++) begin
			es[r] = {1'b0, acc_q[r].esum} + (ESUM_W+1)'(en[r]);
			wn_e[r] = WSUM_W'(acc_q[r].weta) + (WSUM_W+1)'($signed({1'b0, en[r]}) * q_item.eta);
			wn_p[r] = WSUM_W'(acc_q[r].wphi) + (WSUM_W+1)'($signed({1'b0, en[r]}) * q_item.phi);
		end
	end

	function automatic logic signed [WSUM_W-1:0] sat(input logic signed [WSUM_W:0] v);
		if (v[WSUM_W] != v[WSUM_W-1]) sat = {v[WSUM_W], {(WSUM_W-1){~v[WSUM_W]}}};
		else sat = v[WSUM_W-1:0];
	endfunction

	always_comb begin
		if (cur.esum == '0) mphi = '0;
		else if (dq > 511) mphi = 10'sd511;
		else if (dq < -512) mphi = -10'sd512;
		else mphi = dq[9:0];
	end

	crmc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(dnum),
		.divisor(cur.esum), .done(ddone), .quotient(dq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_ACC;
			reg_q <= '0;
			m_valid <= 1'b0;
			m_data <= '0;
			meta_q <= '0;
			dstart <= 1'b0;
			for (int r = 0; r < NREG; r++) acc_q[r] <= '0;
		end else begin
			dstart <= 1'b0;
			unique case (st_q)
				ST_ACC: begin
					if (q_valid) begin
						if (q_item.take) begin
							for (int r = 0; r < NREG; r++) begin
								if (q_item.qual[r] && en[r] > acc_q[r].best_e) begin
									acc_q[r].best_e <= en[r];
									acc_q[r].best_eta <= q_item.eta;
									acc_q[r].best_phi <= q_item.phi;
								end
								if (q_item.flag[r]) begin
									acc_q[r].esum <= es[r][ESUM_W] ? ESUM_MAX : es[r][ESUM_W-1:0];
									acc_q[r].weta <= sat(wn_e[r]);
									acc_q[r].wphi <= sat(wn_p[r]);
								end
							end
						end
						if (q_item.last) begin
							st_q <= ST_DETA;
							reg_q <= '0;
							dstart <= 1'b1;
						end
					end
				end
				ST_DETA: begin
					if (ddone) begin
						if (cur.esum == '0) meta_q <= '0;
						else if (dq > 1023) meta_q <= 11'sd1023;
						else if (dq < -1024) meta_q <= -11'sd1024;
						else meta_q <= dq[10:0];
						st_q <= ST_DPHI;
						dstart <= 1'b1;
					end
				end
				ST_DPHI: begin
					if (ddone) begin
						m_data <= {5'd0, (reg_q == 3'(NREG-1)), (cur.esum != '0), mphi, meta_q,
							cur.esum, cur.best_phi, cur.best_eta, cur.best_e, reg_q};
						m_valid <= 1'b1;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_ready) begin
						m_valid <= 1'b0;
						acc_q[reg_q] <= '0;
						if (reg_q == 3'(NREG-1)) begin
							st_q <= ST_ACC;
						end else begin
							reg_q <= reg_q + 1'b1;
							st_q <= ST_DETA;
							dstart <= 1'b1;
						end
					end
				end
				default: st_q <= ST_ACC;
			endcase
		end
	end
endmodule

@@ sv/calo_region_max_and_centroid_core.sv @@
// top level: calorimeter region peak finder and energy-weighted centroid
// channel | dir | fields
// s_axis  | in  | tdata: tower_present, em, had, total, eta, phi, eb, ee, hb, he, hf; tlast event_end
// m_axis  | out | tdata: region, peak e/eta/phi, energy_total, mean eta/phi, mean_valid; tlast
// towers accumulate at one per cycle while the back part accepts them; a two-entry queue feeds the back part
// at event end, each region runs two 40-step serial divisions (mean eta, then mean phi)
// plus output handshake; towers queue up meanwhile and stall when the queue fills
// arst_n clears all sums, peaks and the tower counter
`timescale 1ns / 1ps
module calo_region_max_and_centroid_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tower_present, em_energy, had_energy, total_energy, tower_eta, tower_phi,
	// in_eb, in_ee, in_hb, in_he, in_hf, zero pad
	input  logic [79:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// region, peak_energy, peak_eta, peak_phi, energy_total, mean_eta, mean_phi,
	// mean_valid, zero pad
	output logic [95:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import crmc_pkg::*;
	item_t s_item, q_item;
	logic q_valid, q_ready;
	logic [95:0] bdata;

	always_comb begin
		s_item.take = s_axis_tdata[0];
		s_item.en_e = s_axis_tdata[16:1];
		s_item.en_h = s_axis_tdata[32:17];
		s_item.en_t = s_axis_tdata[48:33];
		s_item.eta = s_axis_tdata[59:49];
		s_item.phi = s_axis_tdata[69:60];
		s_item.flag = s_axis_tdata[74:70];
		s_item.qual[0] = s_axis_tdata[70] && !s_axis_tdata[71];
		s_item.qual[1] = s_axis_tdata[71] && !s_axis_tdata[70];
		s_item.qual[2] = s_axis_tdata[72] && !s_axis_tdata[73];
		s_item.qual[3] = s_axis_tdata[73] && !s_axis_tdata[72] && !s_axis_tdata[74];
		s_item.qual[4] = s_axis_tdata[74] && !s_axis_tdata[73];
		s_item.last = s_axis_tlast;
	end

	crmc_front u_front (
		.clk(clk), .arst_n(arst_n), .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.s_item(s_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	crmc_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(bdata)
	);

	assign m_axis_tdata = {6'd0, bdata[89:0]};
	assign m_axis_tlast = bdata[90];
endmodule
